// ===== sv/bounded_deque_with_reverse_macros.svh =====
// Assertion macros used by the deque RTL.
`ifndef BOUNDED_DEQUE_WITH_REVERSE_MACROS_SVH
`define BOUNDED_DEQUE_WITH_REVERSE_MACROS_SVH

// Invariant checked at every clock edge outside reset.
`define BDQ_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define BDQ_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BDQ_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bdq_pkg.sv =====
// Types and codes for the bounded deque.
package bdq_pkg;

  localparam int TAG_W = 32;
  localparam int VAL_W = 32;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REVERSE    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  typedef struct packed {
    logic        [TAG_W-1:0] tag;
    logic signed [VAL_W-1:0] value;
  } entry_t;

endpackage

// ===== sv/bdq_ifs.sv =====
// Request and response channel interfaces of the deque.
interface bdq_req_if;
  logic                                valid;
  logic                                ready;
  logic                          [2:0] opcode;
  logic        [bdq_pkg::TAG_W-1:0]    entry_tag;
  logic signed [bdq_pkg::VAL_W-1:0]    entry_value;

  modport source (output valid, output opcode, output entry_tag, output entry_value,
                  input ready);
  modport sink (input valid, input opcode, input entry_tag, input entry_value,
                output ready);
endinterface

interface bdq_rsp_if #(parameter int CNT_W = 5);
  logic                             valid;
  logic                             ready;
  logic                       [1:0] status;
  logic                             popped_valid;
  logic        [bdq_pkg::TAG_W-1:0] popped_tag;
  logic signed [bdq_pkg::VAL_W-1:0] popped_value;
  logic                 [CNT_W-1:0] entry_count;
  logic        [bdq_pkg::TAG_W-1:0] front_tag;
  logic signed [bdq_pkg::VAL_W-1:0] front_value;
  logic        [bdq_pkg::TAG_W-1:0] back_tag;
  logic signed [bdq_pkg::VAL_W-1:0] back_value;

  modport source (output valid, output status, output popped_valid, output popped_tag,
                  output popped_value, output entry_count, output front_tag,
                  output front_value, output back_tag, output back_value, input ready);
  modport sink (input valid, input status, input popped_valid, input popped_tag,
                input popped_value, input entry_count, input front_tag,
                input front_value, input back_tag, input back_value, output ready);
endinterface

// ===== sv/bdq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bdq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/bounded_deque_with_reverse.sv =====
// Bounded double-ended queue with one-step reverse, ring held in a RAM.
//
//   channel | modport | beat
//   req     | sink    | opcode, entry_tag, entry_value
//   rsp     | source  | status, popped entry, entry_count, front and back entries
//
// A pop that leaves one or more entries waits in S_READ before it answers: the new
// front or back entry comes from the ring RAM, whose read data is registered.
// Front and back entries are cached in registers; the RAM holds the whole ring.
// Reset clears the count, front index and direction; RAM contents need no clearing.
// A waiting response holds; req is taken again once rsp is free or being taken.
`include "bounded_deque_with_reverse_macros.svh"

module bounded_deque_with_reverse #(
  parameter int DEPTH = 16
) (
  input logic       clk,
  input logic       rst,
  bdq_req_if.sink   req,
  bdq_rsp_if.source rsp
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ENT_W = $bits(bdq_pkg::entry_t);
  localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO_CNT  = CNT_W'(2);

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? LAST_IDX : i - IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                               input logic rev,
                                               input logic [CNT_W-1:0] pos);
    logic [IDX_W:0] b;
    logic [IDX_W:0] p;
    logic [IDX_W:0] s;
    b = {1'b0, base};
    p = (IDX_W + 1)'(pos);
    if (rev) begin
      s = (b < p) ? b + DEPTH_X - p : b - p;
    end else begin
      s = b + p;
      if (s >= DEPTH_X) begin
        s = s - DEPTH_X;
      end
    end
    return s[IDX_W-1:0];
  endfunction

  bdq_pkg::state_t  state, state_next;
  logic [IDX_W-1:0] front_index, front_index_next;
  logic [CNT_W-1:0] held_count, held_count_next;
  logic             order_reversed, order_reversed_next;
  bdq_pkg::entry_t  front_ent, front_ent_next;
  bdq_pkg::entry_t  back_ent, back_ent_next;
  logic             fill_back, fill_back_next;

  logic             out_valid;
  bdq_pkg::status_t out_status, status_next;
  logic             out_pvalid, pvalid_next;
  bdq_pkg::entry_t  out_popped, popped_next;
  logic [CNT_W-1:0] out_count;
  bdq_pkg::entry_t  out_front, out_back;

  logic             accept, load_out, need_read, is_full, is_empty, is_push;
  bdq_pkg::entry_t  push_ent;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [ENT_W-1:0] ram_rdata;

  assign req.ready = (state == bdq_pkg::S_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign is_full   = (held_count == FULL_CNT);
  assign is_empty  = (held_count == '0);
  assign is_push   = (req.opcode == bdq_pkg::OP_PUSH_FRONT) ||
                     (req.opcode == bdq_pkg::OP_PUSH_BACK);
  assign push_ent  = '{tag: req.entry_tag, value: req.entry_value};

  always_comb begin
    state_next          = state;
    front_index_next    = front_index;
    held_count_next     = held_count;
    order_reversed_next = order_reversed;
    front_ent_next      = front_ent;
    back_ent_next       = back_ent;
    fill_back_next      = fill_back;
    status_next         = bdq_pkg::ST_OK;
    pvalid_next         = 1'b0;
    popped_next         = '0;
    need_read           = 1'b0;
    load_out            = 1'b0;
    ram_we              = 1'b0;
    ram_waddr           = front_index;
    ram_raddr           = front_index;
    unique case (state)
      bdq_pkg::S_IDLE: begin
        if (accept) begin
          case (req.opcode)
            bdq_pkg::OP_PUSH_FRONT: begin
              if (is_full) begin
                status_next = bdq_pkg::ST_FULL;
              end else begin
                front_index_next = order_reversed ? idx_inc(front_index)
                                                  : idx_dec(front_index);
                ram_we          = 1'b1;
                ram_waddr       = front_index_next;
                front_ent_next  = push_ent;
                if (is_empty) begin
                  back_ent_next = push_ent;
                end
                held_count_next = held_count + ONE_CNT;
              end
            end
            bdq_pkg::OP_PUSH_BACK: begin
              if (is_full) begin
                status_next = bdq_pkg::ST_FULL;
              end else begin
                ram_we          = 1'b1;
                ram_waddr       = slot_of(front_index, order_reversed, held_count);
                back_ent_next   = push_ent;
                if (is_empty) begin
                  front_ent_next = push_ent;
                end
                held_count_next = held_count + ONE_CNT;
              end
            end
            bdq_pkg::OP_POP_FRONT: begin
              if (is_empty) begin
                status_next = bdq_pkg::ST_EMPTY;
              end else begin
                pvalid_next      = 1'b1;
                popped_next      = front_ent;
                front_index_next = order_reversed ? idx_dec(front_index)
                                                  : idx_inc(front_index);
                ram_raddr        = front_index_next;
                held_count_next  = held_count - ONE_CNT;
                need_read        = (held_count != ONE_CNT);
                fill_back_next   = 1'b0;
              end
            end
            bdq_pkg::OP_POP_BACK: begin
              if (is_empty) begin
                status_next = bdq_pkg::ST_EMPTY;
              end else begin
                pvalid_next     = 1'b1;
                popped_next     = back_ent;
                ram_raddr       = slot_of(front_index, order_reversed, held_count - TWO_CNT);
                held_count_next = held_count - ONE_CNT;
                need_read       = (held_count != ONE_CNT);
                fill_back_next  = 1'b1;
              end
            end
            bdq_pkg::OP_REVERSE: begin
              if (!is_empty) begin
                front_index_next = slot_of(front_index, order_reversed, held_count - ONE_CNT);
              end
              order_reversed_next = ~order_reversed;
              front_ent_next      = back_ent;
              back_ent_next       = front_ent;
            end
            default: begin
            end
          endcase
          if (need_read) begin
            state_next = bdq_pkg::S_READ;
          end else begin
            load_out = 1'b1;
          end
        end
      end
      bdq_pkg::S_READ: begin
        if (fill_back) begin
          back_ent_next = bdq_pkg::entry_t'(ram_rdata);
        end else begin
          front_ent_next = bdq_pkg::entry_t'(ram_rdata);
        end
        load_out   = 1'b1;
        state_next = bdq_pkg::S_IDLE;
      end
      default: begin
        state_next = bdq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= bdq_pkg::S_IDLE;
      front_index    <= '0;
      held_count     <= '0;
      order_reversed <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      front_index    <= front_index_next;
      held_count     <= held_count_next;
      order_reversed <= order_reversed_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    front_ent <= front_ent_next;
    back_ent  <= back_ent_next;
    fill_back <= fill_back_next;
    if (accept) begin
      out_status <= status_next;
      out_pvalid <= pvalid_next;
      out_popped <= popped_next;
      out_count  <= held_count_next;
    end
    if (load_out) begin
      out_front <= (held_count_next == '0) ? '0 : front_ent_next;
      out_back  <= (held_count_next == '0) ? '0 : back_ent_next;
    end
  end

  bdq_ram #(
    .WIDTH(ENT_W),
    .DEPTH(DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(push_ent),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.popped_valid = out_pvalid;
  assign rsp.popped_tag   = out_popped.tag;
  assign rsp.popped_value = out_popped.value;
  assign rsp.entry_count  = out_count;
  assign rsp.front_tag    = out_front.tag;
  assign rsp.front_value  = out_front.value;
  assign rsp.back_tag     = out_back.tag;
  assign rsp.back_value   = out_back.value;

  `BDQ_ALWAYS(a_count_bound, held_count <= FULL_CNT, "entry count exceeds depth")
  `BDQ_NEXT(a_read_wait, accept && need_read, state == bdq_pkg::S_READ && !rsp.valid, "pop refill did not wait for RAM")
  `BDQ_NEXT(a_full_drop, accept && is_push && is_full, $stable(held_count) && rsp.valid && rsp.status == bdq_pkg::ST_FULL, "push to full store not dropped")
  `BDQ_IMPLIES(a_read_blocks, state == bdq_pkg::S_READ, !req.ready && !out_valid, "beat taken during RAM read")

endmodule
